[rtl/core/wavhp_pkg.sv]
package wavhp_pkg;

   // header layout
   localparam int unsigned HDR_LEN      = 44;
   localparam int unsigned POS_W        = 6;
   localparam int unsigned REQ_DATA_W   = 8;
   localparam int unsigned REQ_USER_W   = 2;
   localparam int unsigned RSP_FIELDS_W = 85;
   localparam int unsigned RSP_DATA_W   = ((RSP_FIELDS_W + 7) / 8) * 8;

   localparam logic [POS_W-1:0] POS_RIFF_LAST = POS_W'(3);
   localparam logic [POS_W-1:0] POS_WAVE_FIRST = POS_W'(8);
   localparam logic [POS_W-1:0] POS_WAVE_LAST = POS_W'(11);
   localparam logic [POS_W-1:0] POS_CHANNELS = POS_W'(22);
   localparam logic [POS_W-1:0] POS_RATE_LAST = POS_W'(27);
   localparam logic [POS_W-1:0] POS_BITS = POS_W'(34);
   localparam logic [POS_W-1:0] POS_DATA_FIRST = POS_W'(36);
   localparam logic [POS_W-1:0] POS_DATA_LAST = POS_W'(39);
   localparam logic [POS_W-1:0] POS_HDR_LAST = POS_W'(HDR_LEN - 1);

   // tags, first byte in the lowest bits
   localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
   localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
   localparam logic [31:0] TAG_DATA = 32'h6174_6164;

   // status codes
   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_BAD_RIFF  = 3'd1;
   localparam logic [2:0] ST_BAD_WAVE  = 3'd2;
   localparam logic [2:0] ST_BAD_DATA  = 3'd3;
   localparam logic [2:0] ST_TRUNCATED = 3'd4;
   localparam logic [2:0] ST_UNSUPP    = 3'd5;

   // audio format codes
   localparam logic [1:0] FMT_MONO8    = 2'd0;
   localparam logic [1:0] FMT_MONO16   = 2'd1;
   localparam logic [1:0] FMT_STEREO8  = 2'd2;
   localparam logic [1:0] FMT_STEREO16 = 2'd3;

   // input kind
   localparam logic KIND_BYTE = 1'b0;
   localparam logic KIND_EOS  = 1'b1;

   typedef struct packed {
      logic [31:0] data_bytes;
      logic [7:0]  sample_bits;
      logic [31:0] sample_rate;
      logic [7:0]  channel_count;
      logic [1:0]  audio_format;
      logic [2:0]  status;
   } result_type;

   function automatic logic [7:0] tag_byte(input logic [31:0] tag, input logic [1:0] idx);
      return tag[{idx, 3'b000} +: 8];
   endfunction

endpackage

[rtl/core/wav_header_parser.sv]
// WAV header parser. Feed a WAV file one byte per transaction on the req_ side; the
// canonical 44-byte header is parsed at fixed offsets. The RIFF, WAVE and data tags are
// checked (a bad tag is reported once its fourth byte is in), and the channel count
// (low byte), sample rate, bits per sample (low byte) and data size are captured
// little-endian. At most one rsp_ transaction is produced per file: status ok with the
// format (mono/stereo, 8/16 bit) and fields, unsupported format (status 5, fields
// still given), a bad tag, or truncated when an end-of-stream item arrives inside the
// header. Error results carry zero fields. Bytes after the result are dropped until
// an item with first_of_file set restarts the parse. Throughput is one item per clock:
// each byte is handled by a position counter and a byte compare in the accepting
// cycle, and the result appears in the output register on the following cycle. The
// block stalls only while that output register holds a result nobody has taken.
module wav_header_parser (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // [7:0] byte_value
   input  logic [wavhp_pkg::REQ_DATA_W-1:0]      req_tdata,
   // [0] kind, [1] first_of_file
   input  logic [wavhp_pkg::REQ_USER_W-1:0]      req_tuser,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // [2:0] status, [4:3] audio_format, [12:5] channel_count, [44:13] sample_rate,
   // [52:45] sample_bits, [84:53] data_bytes, [87:85] zero
   output logic [wavhp_pkg::RSP_DATA_W-1:0]      rsp_tdata
);
   import wavhp_pkg::*;

   // parse state
   logic [POS_W-1:0] byte_pos_ff, byte_pos_in;
   logic             finished_ff, finished_in;
   logic             mismatch_ff, mismatch_in;
   logic [31:0]      shift_ff, shift_in;
   logic [7:0]       channels_ff, channels_in;
   logic [31:0]      rate_ff, rate_in;
   logic [7:0]       bits_ff, bits_in;

   // output register
   logic             rsp_valid_ff, rsp_valid_in;
   result_type       rsp_result_ff, rsp_result_in;

   logic             req_kind, req_first;
   logic [7:0]       req_byte;
   logic             req_accept;

   // state as seen by this transaction (first_of_file restarts it)
   logic [POS_W-1:0] cur_pos;
   logic             cur_finished, cur_mismatch;
   logic [31:0]      cur_shift;
   logic             emit;
   result_type       result;
   logic [31:0]      tag_sel;
   logic             in_tag, tag_last, tag_diff, mismatch_now;
   logic [2:0]       tag_status;

   assign req_kind   = req_tuser[0];
   assign req_first  = req_tuser[1];
   assign req_byte   = req_tdata[7:0];
   // skid-free: take a new transaction whenever the output register is free or draining
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;

   assign cur_pos      = req_first ? '0 : byte_pos_ff;
   assign cur_finished = req_first ? 1'b0 : finished_ff;
   assign cur_mismatch = req_first ? 1'b0 : mismatch_ff;
   assign cur_shift    = req_first ? '0 : shift_ff;

   // tag windows all start on a multiple of four, so pos[1:0] is the byte index
   always_comb begin
      tag_sel    = TAG_RIFF;
      in_tag     = 1'b0;
      tag_last   = 1'b0;
      tag_status = ST_BAD_RIFF;
      priority if (cur_pos <= POS_RIFF_LAST) begin
         in_tag   = 1'b1;
         tag_last = (cur_pos == POS_RIFF_LAST);
      end else if (cur_pos >= POS_WAVE_FIRST && cur_pos <= POS_WAVE_LAST) begin
         tag_sel    = TAG_WAVE;
         in_tag     = 1'b1;
         tag_last   = (cur_pos == POS_WAVE_LAST);
         tag_status = ST_BAD_WAVE;
      end else if (cur_pos >= POS_DATA_FIRST && cur_pos <= POS_DATA_LAST) begin
         tag_sel    = TAG_DATA;
         in_tag     = 1'b1;
         tag_last   = (cur_pos == POS_DATA_LAST);
         tag_status = ST_BAD_DATA;
      end else begin
         in_tag = 1'b0;
      end
   end

   assign tag_diff     = (req_byte != tag_byte(tag_sel, cur_pos[1:0]));
   assign mismatch_now = (cur_pos[1:0] == 2'd0) ? tag_diff : (cur_mismatch || tag_diff);

   always_comb begin
      byte_pos_in = cur_pos;
      finished_in = cur_finished;
      mismatch_in = cur_mismatch;
      shift_in    = cur_shift;
      channels_in = req_first ? '0 : channels_ff;
      rate_in     = req_first ? '0 : rate_ff;
      bits_in     = req_first ? '0 : bits_ff;
      emit        = 1'b0;
      result      = '0;
      if (!cur_finished) begin
         if (req_kind == KIND_EOS) begin
            emit          = 1'b1;
            result.status = ST_TRUNCATED;
         end else begin
            shift_in = {req_byte, cur_shift[31:8]};
            priority if (in_tag) begin
               mismatch_in = mismatch_now;
               if (tag_last && mismatch_now) begin
                  emit          = 1'b1;
                  result.status = tag_status;
               end
            end else if (cur_pos == POS_CHANNELS) begin
               channels_in = req_byte;
            end else if (cur_pos == POS_RATE_LAST) begin
               rate_in = shift_in;
            end else if (cur_pos == POS_BITS) begin
               bits_in = req_byte;
            end else if (cur_pos == POS_HDR_LAST) begin
               emit                 = 1'b1;
               result.status        = ST_OK;
               result.channel_count = channels_in;
               result.sample_rate   = rate_in;
               result.sample_bits   = bits_in;
               result.data_bytes    = shift_in;
               priority if (channels_in == 8'd1 && bits_in == 8'd8) begin
                  result.audio_format = FMT_MONO8;
               end else if (channels_in == 8'd1 && bits_in == 8'd16) begin
                  result.audio_format = FMT_MONO16;
               end else if (channels_in == 8'd2 && bits_in == 8'd8) begin
                  result.audio_format = FMT_STEREO8;
               end else if (channels_in == 8'd2 && bits_in == 8'd16) begin
                  result.audio_format = FMT_STEREO16;
               end else begin
                  result.audio_format = FMT_MONO8;
                  result.status       = ST_UNSUPP;
               end
            end else begin
               result = '0;
            end
            if (!emit) begin
               byte_pos_in = cur_pos + POS_W'(1);
            end
         end
         if (emit) begin
            finished_in = 1'b1;
         end
      end
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_result_in = rsp_result_ff;
      if (req_accept && emit) begin
         rsp_valid_in  = 1'b1;
         rsp_result_in = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_pos_ff  <= '0;
         finished_ff  <= 1'b0;
         mismatch_ff  <= 1'b0;
         shift_ff     <= '0;
         channels_ff  <= '0;
         rate_ff      <= '0;
         bits_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_accept) begin
            byte_pos_ff <= byte_pos_in;
            finished_ff <= finished_in;
            mismatch_ff <= mismatch_in;
            shift_ff    <= shift_in;
            channels_ff <= channels_in;
            rate_ff     <= rate_in;
            bits_ff     <= bits_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_result_ff <= rsp_result_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_DATA_W - RSP_FIELDS_W)'(0), rsp_result_ff};

   // ---- assertions ----
   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      byte_pos_ff <= POS_HDR_LAST)
      else $error("byte position past header end");

   a_ok_format: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_result_ff.status == ST_OK |->
         (rsp_result_ff.channel_count == 8'd1 || rsp_result_ff.channel_count == 8'd2) &&
         (rsp_result_ff.sample_bits == 8'd8 || rsp_result_ff.sample_bits == 8'd16))
      else $error("ok result with unsupported format");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_result_ff.status != ST_OK && rsp_result_ff.status != ST_UNSUPP |->
         rsp_result_ff.audio_format == '0 && rsp_result_ff.channel_count == '0 &&
         rsp_result_ff.sample_rate == '0 && rsp_result_ff.sample_bits == '0 &&
         rsp_result_ff.data_bytes == '0)
      else $error("error result with non-zero fields");

   a_empty_file: assert property (@(posedge clock) disable iff (reset)
      req_accept && req_first && req_kind == KIND_EOS |=>
         rsp_tvalid && rsp_result_ff.status == ST_TRUNCATED && finished_ff)
      else $error("empty file not reported as truncated");

   a_first_byte: assert property (@(posedge clock) disable iff (reset)
      req_accept && req_first && req_kind == KIND_BYTE |=>
         byte_pos_ff == POS_W'(1) && !finished_ff)
      else $error("restart did not begin a fresh parse");

endmodule

[tb/wav_header_checker.sv]
module wav_header_checker (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   input  logic                                 req_tready,
   // [7:0] byte_value
   input  logic [wavhp_pkg::REQ_DATA_W-1:0]     req_tdata,
   // [0] kind, [1] first_of_file
   input  logic [wavhp_pkg::REQ_USER_W-1:0]     req_tuser,
   input  logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // [2:0] status, [4:3] audio_format, [12:5] channel_count, [44:13] sample_rate,
   // [52:45] sample_bits, [84:53] data_bytes, [87:85] zero
   input  logic [wavhp_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output int unsigned                          failures,
   output int unsigned                          pending
);
   timeunit 1ns;
   timeprecision 1ps;
   import wavhp_pkg::*;

   // parser state
   logic [POS_W-1:0] pos;
   logic             done_flag;
   logic             tag_bad;
   logic [31:0]      shift_reg;
   logic [7:0]       ch_low;
   logic [31:0]      rate_word;
   logic [7:0]       bits_low;

   result_type expected_results[$];

   task automatic clear_parse();
      pos       = '0;
      done_flag = 1'b0;
      tag_bad   = 1'b0;
      shift_reg = '0;
      ch_low    = '0;
      rate_word = '0;
      bits_low  = '0;
   endtask

   task automatic mark_tag(input logic [31:0] tag, input logic [1:0] idx, input logic [7:0] b);
      logic diff;
      diff    = (b != tag[8*idx +: 8]);
      tag_bad = (idx == 2'd0) ? diff : (tag_bad | diff);
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
         failures++;
      end
   endtask

   // one header byte or end of stream; queues the result it causes, if any
   task automatic parse_wav_item(input logic kind, input logic [7:0] b, input logic first);
      result_type       r;
      logic [POS_W-1:0] p;
      logic             give;
      if (first)
         clear_parse();
      if (done_flag)
         return;
      r    = '0;
      give = 1'b0;
      p    = pos;
      if (kind == KIND_EOS) begin
         r.status = ST_TRUNCATED;
         give     = 1'b1;
      end else begin
         shift_reg = {b, shift_reg[31:8]};
         // all tags start on a multiple of four, so the low bits index the tag byte
         if (p <= POS_RIFF_LAST) begin
            mark_tag(TAG_RIFF, p[1:0], b);
            if (p == POS_RIFF_LAST && tag_bad) begin
               r.status = ST_BAD_RIFF;
               give     = 1'b1;
            end
         end else if (p >= POS_WAVE_FIRST && p <= POS_WAVE_LAST) begin
            mark_tag(TAG_WAVE, p[1:0], b);
            if (p == POS_WAVE_LAST && tag_bad) begin
               r.status = ST_BAD_WAVE;
               give     = 1'b1;
            end
         end else if (p == POS_CHANNELS) begin
            ch_low = b;
         end else if (p == POS_RATE_LAST) begin
            rate_word = shift_reg;
         end else if (p == POS_BITS) begin
            bits_low = b;
         end else if (p >= POS_DATA_FIRST && p <= POS_DATA_LAST) begin
            mark_tag(TAG_DATA, p[1:0], b);
            if (p == POS_DATA_LAST && tag_bad) begin
               r.status = ST_BAD_DATA;
               give     = 1'b1;
            end
         end else if (p == POS_HDR_LAST) begin
            give            = 1'b1;
            r.status        = ST_OK;
            r.channel_count = ch_low;
            r.sample_rate   = rate_word;
            r.sample_bits   = bits_low;
            r.data_bytes    = shift_reg;
            case ({ch_low, bits_low})
               {8'd1, 8'd8}:  r.audio_format = FMT_MONO8;
               {8'd1, 8'd16}: r.audio_format = FMT_MONO16;
               {8'd2, 8'd8}:  r.audio_format = FMT_STEREO8;
               {8'd2, 8'd16}: r.audio_format = FMT_STEREO16;
               default:       r.status = ST_UNSUPP;
            endcase
         end
         pos = p + 1'b1;
      end
      if (give) begin
         done_flag = 1'b1;
         expected_results.push_back(r);
      end
   endtask

   always @(posedge clock) begin
      result_type want, got;
      if (reset) begin
         clear_parse();
         expected_results.delete();
      end else begin
         // a result always comes out after its item is taken, so compare before predicting
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[RSP_FIELDS_W-1:0];
            if (expected_results.size() == 0) begin
               $error("unexpected result transaction: 0x%0h", rsp_tdata);
               failures++;
            end else begin
               want = expected_results.pop_front();
               check_field("status", 32'(want.status), 32'(got.status));
               check_field("audio_format", 32'(want.audio_format), 32'(got.audio_format));
               check_field("channel_count", 32'(want.channel_count), 32'(got.channel_count));
               check_field("sample_rate", want.sample_rate, got.sample_rate);
               check_field("sample_bits", 32'(want.sample_bits), 32'(got.sample_bits));
               check_field("data_bytes", want.data_bytes, got.data_bytes);
               check_field("padding", 32'd0, 32'(rsp_tdata[RSP_DATA_W-1:RSP_FIELDS_W]));
            end
         end
         if (req_tvalid && req_tready)
            parse_wav_item(req_tuser[0], req_tdata, req_tuser[1]);
      end
      pending <= expected_results.size();
   end

endmodule

[tb/tb_wav_header_parser.sv]
module tb_wav_header_parser;
   timeunit 1ns;
   timeprecision 1ps;
   import wavhp_pkg::*;

   localparam int unsigned ITEM_TARGET = 1750;
   localparam int unsigned HOLD_CYCLES = 300;   // long receiver hold-off
   localparam int unsigned IDLE_LIMIT  = 2000;  // cycles with no transaction at all
   localparam int unsigned TAIL_CYCLES = 20;    // watch for stray results at the end
   localparam int unsigned HOLD_FILE   = 12;
   localparam int unsigned DRAIN_FILE  = 30;

   logic                    clock = 1'b0;
   logic                    reset;
   logic                    req_tvalid;
   logic                    req_tready;
   logic [REQ_DATA_W-1:0]   req_tdata;     // [7:0] byte_value
   logic [REQ_USER_W-1:0]   req_tuser;     // [0] kind, [1] first_of_file
   logic                    rsp_tvalid;
   logic                    rsp_tready;
   // [2:0] status, [4:3] audio_format, [12:5] channel_count, [44:13] sample_rate,
   // [52:45] sample_bits, [84:53] data_bytes, [87:85] zero
   logic [RSP_DATA_W-1:0]   rsp_tdata;
   int unsigned             failures;
   int unsigned             pending;

   typedef struct {
      logic       kind;
      logic [7:0] value;
      logic       first;
   } stream_item_type;

   typedef enum int unsigned {
      FC_OK, FC_UNSUPP, FC_BAD_RIFF, FC_BAD_WAVE, FC_BAD_DATA, FC_TRUNC, FC_NOISE
   } file_case_type;

   stream_item_type file_items[$];
   int unsigned useful_items = 0;
   int unsigned file_no = 0;
   int unsigned idle_cycles = 0;
   bit          send_gappy = 1'b0;
   bit          rsp_gappy = 1'b0;
   bit          long_hold = 1'b0;

   always #1 clock = ~clock;

   wav_header_parser dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   wav_header_checker scoreboard (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .failures   (failures),
      .pending    (pending)
   );

   // mostly short gaps, now and then a long one
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 80)
         return $urandom_range(1, 3);
      if (r < 95)
         return $urandom_range(4, 12);
      return $urandom_range(20, 40);
   endfunction

   // 32-bit field with its extremes favoured
   function automatic logic [31:0] rand_word();
      case ($urandom_range(0, 5))
         0:       return 32'h0000_0000;
         1:       return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [7:0] rand_byte();
      case ($urandom_range(0, 3))
         0:       return 8'h00;
         1:       return 8'hFF;
         default: return 8'($urandom);
      endcase
   endfunction

   function automatic void push_byte(input logic [7:0] b, input logic first);
      file_items.push_back('{KIND_BYTE, b, first});
   endfunction

   function automatic void push_eos(input logic first);
      file_items.push_back('{KIND_EOS, 8'($urandom), first});
   endfunction

   // Offer one transaction and hold it until taken. Handshake is judged at the
   // falling edge, where everything the next rising edge samples is settled.
   task automatic send_item(input stream_item_type it);
      logic accepted;
      if (send_gappy && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat (pick_gap()) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= it.value;
      req_tuser  <= {it.first, it.kind};
      do begin
         @(negedge clock);
         accepted = req_tready;
         @(posedge clock);
      end while (!accepted);
   endtask

   task automatic send_file();
      while (file_items.size() > 0)
         send_item(file_items.pop_front());
   endtask

   // stop offering and wait until every predicted result has come out
   task automatic drain();
      req_tvalid <= 1'b0;
      @(negedge clock);
      wait (pending == 0);
      @(posedge clock);
   endtask

   // Build one file: a canonical header, spoilt as the case asks, then up to four
   // trailing items the block should ignore; the noise case gives loose items only.
   task automatic make_file(input file_case_type fc);
      logic [15:0] chans, bits;
      logic [31:0] rate, size;
      logic [7:0]  hdr [HDR_LEN];
      int unsigned cut, k, n;
      if (fc == FC_NOISE) begin
         // loose items, restarts and ends of stream at random
         n = $urandom_range(1, 12);
         repeat (n) begin
            if ($urandom_range(0, 4) == 0)
               push_eos($urandom_range(0, 9) == 0);
            else
               push_byte(rand_byte(), $urandom_range(0, 9) == 0);
         end
         useful_items += n;
         return;
      end
      chans = 16'($urandom_range(1, 2));
      bits  = $urandom_range(0, 1) ? 16'd16 : 16'd8;
      if (file_no < 4) begin
         // first files walk through all four formats
         chans = 16'(1 + file_no / 2);
         bits  = (file_no % 2) ? 16'd16 : 16'd8;
      end
      if ($urandom_range(0, 3) == 0) begin
         // only the low bytes classify
         chans[15:8] = rand_byte();
         bits[15:8]  = rand_byte();
      end
      if (fc == FC_UNSUPP) begin
         if ($urandom_range(0, 1))
            chans[7:0] = rand_byte();
         else
            bits[7:0] = rand_byte();
      end
      rate = rand_word();
      size = rand_word();
      foreach (hdr[i])
         hdr[i] = 8'($urandom);
      for (int i = 0; i < 4; i++) begin
         hdr[i]      = TAG_RIFF[8*i +: 8];
         hdr[8 + i]  = TAG_WAVE[8*i +: 8];
         hdr[36 + i] = TAG_DATA[8*i +: 8];
         hdr[24 + i] = rate[8*i +: 8];
         hdr[40 + i] = size[8*i +: 8];
      end
      hdr[22] = chans[7:0];
      hdr[23] = chans[15:8];
      hdr[34] = bits[7:0];
      hdr[35] = bits[15:8];

      cut = HDR_LEN;
      k   = HDR_LEN;   // no corruption
      case (fc)
         FC_BAD_RIFF: k = $urandom_range(0, 3);
         FC_BAD_WAVE: k = $urandom_range(8, 11);
         FC_BAD_DATA: k = $urandom_range(36, 39);
         FC_TRUNC: begin
            cut = $urandom_range(0, HDR_LEN - 1);
            // sometimes a tag is already wrong when the stream runs dry
            if ($urandom_range(0, 2) == 0) begin
               n = $urandom_range(0, 2);
               k = $urandom_range(0, 3) + ((n == 0) ? 0 : (n == 1) ? 8 : 36);
            end
         end
         default: ;
      endcase
      if (k < HDR_LEN)
         hdr[k] = hdr[k] ^ (8'd1 << $urandom_range(0, 7));

      for (int i = 0; i < cut; i++)
         push_byte(hdr[i], i == 0);
      if (cut < HDR_LEN)
         push_eos(cut == 0);
      useful_items += cut + 1;

      // trailing payload, or a late end of stream, neither of which answers
      n = $urandom_range(0, 4);
      repeat (n) begin
         if ($urandom_range(0, 4) == 0)
            push_eos(1'b0);
         else
            push_byte(8'($urandom), 1'b0);
      end
   endtask

   // receiver: ready runs, random gaps, and one long hold-off on request
   initial begin
      rsp_tready <= 1'b0;
      @(negedge reset);
      forever begin
         if (long_hold) begin
            long_hold = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else if (rsp_gappy && $urandom_range(0, 2) == 0) begin
            rsp_tready <= 1'b0;
            repeat (pick_gap()) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   // watchdog: give up when no transaction moves on either side for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("wav_header_parser test failed");
            $finish;
         end
      end
   end

   initial begin
      file_case_type fc;
      int unsigned   r;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed: empty file, then an end of stream and a byte after the result
      push_eos(1'b1);
      push_eos(1'b0);
      push_byte(8'hFF, 1'b0);
      // RIFF wrong in its first byte, reported on the fourth
      push_byte(8'h00, 1'b1);
      push_byte(TAG_RIFF[15:8], 1'b0);
      push_byte(TAG_RIFF[23:16], 1'b0);
      push_byte(TAG_RIFF[31:24], 1'b0);
      // tag already wrong but the stream ends first: truncated wins
      push_byte(8'hFF, 1'b1);
      push_byte(TAG_RIFF[15:8], 1'b0);
      push_eos(1'b0);
      // restart in the middle of a header
      push_byte(TAG_RIFF[7:0], 1'b1);
      push_byte(TAG_RIFF[15:8], 1'b0);
      push_byte(TAG_RIFF[23:16], 1'b0);
      for (int i = 0; i < 4; i++)
         push_byte(TAG_RIFF[8*i +: 8], i == 0);
      push_eos(1'b0);
      send_file();

      // random files, mostly well formed headers with random content
      while (useful_items < ITEM_TARGET) begin
         send_gappy = ($urandom_range(0, 3) != 0);
         rsp_gappy  = ($urandom_range(0, 3) != 0);
         if (file_no == HOLD_FILE) begin
            // receiver stops for a long while; back-to-back empty files fill the
            // output register and the input must stall
            send_gappy = 1'b0;
            long_hold  = 1'b1;
            repeat (8)
               push_eos(1'b1);
            useful_items += 8;
            send_file();
         end
         if (file_no == DRAIN_FILE)
            drain();
         case (file_no)
            0, 1, 2, 3: fc = FC_OK;
            4:          fc = FC_UNSUPP;
            5:          fc = FC_BAD_WAVE;
            6:          fc = FC_BAD_DATA;
            7:          fc = FC_TRUNC;
            8:          fc = FC_BAD_RIFF;
            default: begin
               r = $urandom_range(0, 99);
               if (r < 35)
                  fc = FC_OK;
               else if (r < 45)
                  fc = FC_UNSUPP;
               else if (r < 53)
                  fc = FC_BAD_RIFF;
               else if (r < 61)
                  fc = FC_BAD_WAVE;
               else if (r < 69)
                  fc = FC_BAD_DATA;
               else if (r < 89)
                  fc = FC_TRUNC;
               else
                  fc = FC_NOISE;
            end
         endcase
         make_file(fc);
         send_file();
         file_no++;
      end

      drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (failures == 0)
         $display("wav_header_parser test passed");
      else
         $display("wav_header_parser test failed");
      $finish;
   end

endmodule

[sim.f]
rtl/core/wavhp_pkg.sv
rtl/core/wav_header_parser.sv
tb/wav_header_checker.sv
tb/tb_wav_header_parser.sv
